### src/pidss_pkg.sv
// pidss_pkg: shared types and constants for the PID step with standstill block.
// Holds the configuration register struct, register indexes and reset values.
// No dependencies.
package pidss_pkg;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_GAIN_P          = 3'd0;
  localparam logic [2:0] REG_GAIN_I          = 3'd1;
  localparam logic [2:0] REG_GAIN_D          = 3'd2;
  localparam logic [2:0] REG_INTEGRAL_WINDOW = 3'd3;
  localparam logic [2:0] REG_INTEGRAL_LIMIT  = 3'd4;
  localparam logic [2:0] REG_OUTPUT_LIMIT    = 3'd5;
  localparam logic [2:0] REG_STILL_MAX_COUNT = 3'd6;
  localparam logic [2:0] REG_STILL_MAX_STEP  = 3'd7;

  localparam int unsigned ADDR_W = 5;
  localparam logic [14:0] OUTPUT_LIMIT_RST = 15'd12000;
  localparam logic [7:0]  COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [22:0] integral_window;
    logic [30:0] integral_limit;
    logic [14:0] output_limit;
    logic [7:0]  still_max_count;
    logic [23:0] still_max_step;
  } pidss_cfg_t;

  // pipeline enables from the top-level flow control
  typedef struct packed {
    logic adv1;  // stage 0 item moves into stage 1, state updates
    logic en2;   // stage 2 product registers load
    logic en3;   // result register loads
  } pidss_pipe_t;

endpackage

### src/pidss_regs.sv
// pidss_regs: APB-style configuration register file.
// Depends on pidss_pkg for the register struct and indexes.
module pidss_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [4:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output pidss_pkg::pidss_cfg_t     cfg
);
  import pidss_pkg::*;

  pidss_cfg_t cfg_r;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p          <= '0;
      cfg_r.gain_i          <= '0;
      cfg_r.gain_d          <= '0;
      cfg_r.integral_window <= '0;
      cfg_r.integral_limit  <= '0;
      cfg_r.output_limit    <= OUTPUT_LIMIT_RST;
      cfg_r.still_max_count <= '0;
      cfg_r.still_max_step  <= '0;
    end else if (wr) begin
      case (idx)
        REG_GAIN_P:          cfg_r.gain_p          <= pwdata[15:0];
        REG_GAIN_I:          cfg_r.gain_i          <= pwdata[15:0];
        REG_GAIN_D:          cfg_r.gain_d          <= pwdata[15:0];
        REG_INTEGRAL_WINDOW: cfg_r.integral_window <= pwdata[22:0];
        REG_INTEGRAL_LIMIT:  cfg_r.integral_limit  <= pwdata[30:0];
        REG_OUTPUT_LIMIT:    cfg_r.output_limit    <= pwdata[14:0];
        REG_STILL_MAX_COUNT: cfg_r.still_max_count <= pwdata[7:0];
        REG_STILL_MAX_STEP:  cfg_r.still_max_step  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_GAIN_P:          prdata = {16'd0, cfg_r.gain_p};
      REG_GAIN_I:          prdata = {16'd0, cfg_r.gain_i};
      REG_GAIN_D:          prdata = {16'd0, cfg_r.gain_d};
      REG_INTEGRAL_WINDOW: prdata = {9'd0, cfg_r.integral_window};
      REG_INTEGRAL_LIMIT:  prdata = {1'b0, cfg_r.integral_limit};
      REG_OUTPUT_LIMIT:    prdata = {17'd0, cfg_r.output_limit};
      REG_STILL_MAX_COUNT: prdata = {24'd0, cfg_r.still_max_count};
      REG_STILL_MAX_STEP:  prdata = {8'd0, cfg_r.still_max_step};
      default:             prdata = '0;
    endcase
  end

endmodule

### src/pidss_state.sv
// pidss_state: controller state (integral, last error, standstill) and stage 1.
// Updates the state once per transaction and registers e, integral and derivative.
// Depends on pidss_pkg.
module pidss_state (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pidss_pkg::pidss_cfg_t     cfg,
  input  pidss_pkg::pidss_pipe_t    pipe,
  input  logic signed [23:0]        e0,
  input  logic                      start0,
  output logic signed [23:0]        e1,
  output logic signed [31:0]        i1,
  output logic signed [24:0]        d1,
  output logic                      f1
);
  import pidss_pkg::*;

  logic signed [31:0] isum_r, isum_nxt;
  logic signed [23:0] prev_r;
  logic [7:0]         cnt_r, cnt_nxt;
  logic               flag_r, flag_nxt;

  logic signed [23:0] e1_r;
  logic signed [31:0] i1_r;
  logic signed [24:0] d1_r;
  logic               f1_r;

  logic signed [31:0] isum_eff;
  logic signed [23:0] prev_eff;
  logic [7:0]         cnt_eff, cnt_inc;
  logic               flag_eff;
  logic [23:0]        e_mag;
  logic signed [24:0] d;
  logic [24:0]        d_mag;
  logic signed [32:0] s, lim, lim_n;

  always_comb begin
    // start clears state before the tick
    isum_eff = start0 ? '0 : isum_r;
    prev_eff = start0 ? '0 : prev_r;
    cnt_eff  = start0 ? '0 : cnt_r;
    flag_eff = start0 ? 1'b0 : flag_r;

    e_mag = e0[23] ? 24'(-e0) : 24'(e0);
    d     = 25'(e0) - 25'(prev_eff);
    d_mag = d[24] ? 25'(-d) : 25'(d);

    // integral: reset on sign change or outside window, else accumulate and clamp
    lim   = $signed({2'b00, cfg.integral_limit});
    lim_n = -lim;
    s     = 33'(isum_eff) + 33'(e0);
    if (e0[23] != prev_eff[23]) begin
      isum_nxt = '0;
    end else if ({1'b0, e_mag} <= {2'b00, cfg.integral_window}) begin
      if (s > lim)        isum_nxt = lim[31:0];
      else if (s < lim_n) isum_nxt = lim_n[31:0];
      else                isum_nxt = s[31:0];
    end else begin
      isum_nxt = '0;
    end

    // standstill: saturating small-step count, sticky flag
    cnt_inc  = (cnt_eff == COUNT_MAX) ? COUNT_MAX : cnt_eff + 8'd1;
    flag_nxt = flag_eff;
    if (cfg.still_max_count != 8'd0 && d_mag <= {1'b0, cfg.still_max_step}) begin
      cnt_nxt = cnt_inc;
      if (cnt_inc > cfg.still_max_count) flag_nxt = 1'b1;
    end else begin
      cnt_nxt = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isum_r <= '0;
      prev_r <= '0;
      cnt_r  <= '0;
      flag_r <= 1'b0;
    end else if (pipe.adv1) begin
      isum_r <= isum_nxt;
      prev_r <= e0;
      cnt_r  <= cnt_nxt;
      flag_r <= flag_nxt;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (pipe.adv1) begin
      e1_r <= e0;
      i1_r <= isum_nxt;
      d1_r <= d;
      f1_r <= flag_nxt;
    end
  end

  assign e1 = e1_r;
  assign i1 = i1_r;
  assign d1 = d1_r;
  assign f1 = f1_r;

  // standstill flag is sticky until a start
  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe.adv1 && !start0 && flag_r) |=> flag_r)
    else $error("standstill flag dropped without start");

  // flag can only rise when detection is enabled
  a_flag_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(flag_r) |-> (cfg.still_max_count != 8'd0))
    else $error("standstill flag set while detection disabled");

endmodule

### src/pidss_mac.sv
// pidss_mac: gain multiplies (stage 2), then sum, floor shift and clamp (stage 3).
// Drives the result register. Depends on pidss_pkg.
module pidss_mac (
  input  logic                      clk,
  input  pidss_pkg::pidss_cfg_t     cfg,
  input  pidss_pkg::pidss_pipe_t    pipe,
  input  logic signed [23:0]        e1,
  input  logic signed [31:0]        i1,
  input  logic signed [24:0]        d1,
  input  logic                      f1,
  output logic signed [15:0]        drive,
  output logic                      still
);
  import pidss_pkg::*;

  logic signed [40:0] pp_r;
  logic signed [48:0] pi_r;
  logic signed [41:0] pd_r;
  logic               f2_r;
  logic signed [15:0] drive_r;
  logic               f3_r;

  logic signed [50:0] acc;
  logic signed [34:0] y, lim, lim_n;
  logic signed [15:0] y_c;

  // stage 2: three independent products
  always_ff @(posedge clk) begin
    if (pipe.en2) begin
      pp_r <= $signed({1'b0, cfg.gain_p}) * e1;
      pi_r <= $signed({1'b0, cfg.gain_i}) * i1;
      pd_r <= $signed({1'b0, cfg.gain_d}) * d1;
      f2_r <= f1;
    end
  end

  // stage 3: sum, arithmetic shift (floor), symmetric clamp
  always_comb begin
    acc   = 51'(pp_r) + 51'(pi_r) + 51'(pd_r);
    y     = acc[50:16];
    lim   = $signed({20'd0, cfg.output_limit});
    lim_n = -lim;
    if (y > lim)        y_c = lim[15:0];
    else if (y < lim_n) y_c = lim_n[15:0];
    else                y_c = y[15:0];
  end

  always_ff @(posedge clk) begin
    if (pipe.en3) begin
      drive_r <= y_c;
      f3_r    <= f2_r;
    end
  end

  assign drive = drive_r;
  assign still = f3_r;

endmodule

### src/pid_step_with_standstill.sv
// pid_step_with_standstill: top level, input register, pipeline flow control.
// Depends on pidss_pkg, pidss_regs, pidss_state, pidss_mac.
//
// Usage:
//   Input channel (in_valid/in_stall): one control tick per transaction,
//   an error sample (signed Q16.8) and a start flag that clears the
//   controller state before the tick.
//   Output channel (out_valid/out_stall): one transaction per tick, the
//   clamped drive value and the sticky standstill flag.
//   Configuration: APB-style port, register i at byte address 4*i, a
//   setup and an access phase, pready always high. Write only while idle.
//   Pipeline: input register, then state update, multiply and sum/clamp
//   into the result register, each stage registered.
//   Throughput: one tick per cycle while the output is not stalled; the
//   integral and last-error feedback closes within the state update stage.
//   Stall: each stage holds when the next one is full and held, so empty
//   stages keep taking ticks while a result waits; in_stall rises only once
//   all four stages are full behind a stalled result.
//   Reset: rst_n synchronous, clears state, pipeline and registers
//   (output_limit resets to 12000, all others to 0).
module pid_step_with_standstill (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_error_now,
  input  logic               in_start_move,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_drive_value,
  output logic               out_standing_still,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pidss_pkg::*;

  pidss_cfg_t  cfg;
  pidss_pipe_t pipe;

  logic v0_r, v1_r, v2_r, v3_r;
  logic rdy0, rdy1, rdy2, rdy3;
  logic signed [23:0] e0_r;
  logic               start0_r;

  logic signed [23:0] e1;
  logic signed [31:0] i1;
  logic signed [24:0] d1;
  logic               f1;

  // backpressure chain: a stage loads when empty or when it drains
  assign rdy3 = !v3_r || !out_stall;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  assign in_stall  = !rdy0;
  assign out_valid = v3_r;

  assign pipe.adv1 = v0_r && rdy1;
  assign pipe.en2  = rdy2;
  assign pipe.en3  = rdy3;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rdy0) begin
      e0_r     <= in_error_now;
      start0_r <= in_start_move;
    end
  end

  pidss_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pidss_state u_state (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .pipe   (pipe),
    .e0     (e0_r),
    .start0 (start0_r),
    .e1     (e1),
    .i1     (i1),
    .d1     (d1),
    .f1     (f1)
  );

  pidss_mac u_mac (
    .clk   (clk),
    .cfg   (cfg),
    .pipe  (pipe),
    .e1    (e1),
    .i1    (i1),
    .d1    (d1),
    .f1    (f1),
    .drive (out_drive_value),
    .still (out_standing_still)
  );

  // input side stalls only with the whole pipeline full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v0_r && v1_r && v2_r && v3_r && out_stall))
    else $error("input stalled with room in pipeline");

  // a drained result is replaced by the item behind it
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_stall && v2_r) |=> v3_r)
    else $error("result lost a following item");

endmodule

### tb/tb.sv
// tb: self-checking testbench for pid_step_with_standstill.
// Drives control ticks and APB register writes, predicts each drive command
// and standstill flag, and checks every result. Depends on pidss_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pidss_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_TICKS = 75;

  typedef enum {SET_HIGH, SET_LOW, SET_RANDOM} setting_kind_t;

  // one directed tick; drive/still are used only where typed is set
  typedef struct {
    logic signed [23:0] err;
    bit                 start;
    bit                 new_setup;
    bit                 typed;
    logic signed [15:0] drive;
    bit                 still;
  } tick_row_t;

  typedef struct {
    logic signed [15:0] drive;
    bit                 still;
  } drive_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [23:0] in_error_now;
  logic               in_start_move;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_drive_value;
  logic               out_standing_still;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  pid_step_with_standstill uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_error_now       (in_error_now),
    .in_start_move      (in_start_move),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_value    (out_drive_value),
    .out_standing_still (out_standing_still),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // controller copy used for prediction
  pidss_cfg_t ctl_cfg;
  longint     integ_sum;
  longint     last_err;
  int         still_cnt;
  bit         still_on;

  drive_result_t pending_drive[$];

  int  mismatches;
  int  ticks_sent;
  int  settings_loaded;
  int  results_checked;
  int  still_seen;
  int  cycles;
  int  stall_left;
  bit  steady_flow;
  bit  steady_run;
  longint walk_err;

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_drive.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // one control tick of the controller: integral, derivative, standstill, output
  task automatic compute_drive(input logic signed [23:0] err, input bit start,
                               output logic signed [15:0] drive, output bit still);
    longint e, d, acc, y, lim, s, win, stp, cnt_max, gp, gi, gd;
    e       = err;
    win     = ctl_cfg.integral_window;
    stp     = ctl_cfg.still_max_step;
    cnt_max = ctl_cfg.still_max_count;
    gp      = ctl_cfg.gain_p;
    gi      = ctl_cfg.gain_i;
    gd      = ctl_cfg.gain_d;
    if (start) begin
      integ_sum = 0;
      last_err  = 0;
      still_cnt = 0;
      still_on  = 1'b0;
    end
    // integral: cleared on sign change or outside the window
    if ((e < 0) != (last_err < 0)) begin
      integ_sum = 0;
    end else if (magnitude(e) <= win) begin
      lim = ctl_cfg.integral_limit;
      s   = integ_sum + e;
      if (s > lim) s = lim;
      if (s < -lim) s = -lim;
      integ_sum = s;
    end else begin
      integ_sum = 0;
    end
    d = e - last_err;
    // standstill: saturating count of small steps, sticky flag
    if (cnt_max != 0 && magnitude(last_err - e) <= stp) begin
      if (still_cnt < 255) still_cnt++;
      if (still_cnt > cnt_max) still_on = 1'b1;
    end else begin
      still_cnt = 0;
    end
    acc = gp * e + gi * integ_sum + gd * d;
    y   = acc >>> 16;
    lim = ctl_cfg.output_limit;
    if (y > lim) y = lim;
    if (y < -lim) y = -lim;
    last_err = e;
    drive = y[15:0];
    still = still_on;
  endtask

  // result side: compare and draw receiver stalls
  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (out_standing_still) still_seen++;
      if (pending_drive.size() == 0) begin
        flag_mismatch("unexpected result, drive", 0, out_drive_value);
      end else begin
        want = pending_drive.pop_front();
        if (out_drive_value !== want.drive)
          flag_mismatch("drive_value", want.drive, out_drive_value);
        if (out_standing_still !== want.still)
          flag_mismatch("standing_still", want.still, out_standing_still);
      end
      stall_left = steady_flow ? 0 : $urandom_range(0, 5);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // send one tick, then record what it should produce
  task automatic send_tick(input logic signed [23:0] err, input bit start, input bit typed,
                           input logic signed [15:0] t_drive, input bit t_still);
    int gap;
    drive_result_t r;
    logic signed [15:0] p_drive;
    bit p_still;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_error_now  <= err;
    in_start_move <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    compute_drive(err, start, p_drive, p_still);
    r.drive = typed ? t_drive : p_drive;
    r.still = typed ? t_still : p_still;
    pending_drive.push_back(r);
    ticks_sent++;
  endtask

  // hold the input until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_drive.size() != 0);
  endtask

  task automatic apb_xfer(input bit wr, input logic [4:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] reg_value(input pidss_cfg_t c, input logic [2:0] idx);
    case (idx)
      REG_GAIN_P:          return 32'(c.gain_p);
      REG_GAIN_I:          return 32'(c.gain_i);
      REG_GAIN_D:          return 32'(c.gain_d);
      REG_INTEGRAL_WINDOW: return 32'(c.integral_window);
      REG_INTEGRAL_LIMIT:  return 32'(c.integral_limit);
      REG_OUTPUT_LIMIT:    return 32'(c.output_limit);
      REG_STILL_MAX_COUNT: return 32'(c.still_max_count);
      REG_STILL_MAX_STEP:  return 32'(c.still_max_step);
      default:             return '0;
    endcase
  endfunction

  // write all registers, read each back; block must be idle
  task automatic load_settings(input pidss_cfg_t c);
    logic [2:0]  idx;
    logic [31:0] rd;
    for (int i = 0; i < 8; i++) begin
      idx = i[2:0];
      apb_xfer(1'b1, {idx, 2'b00}, reg_value(c, idx), rd);
      apb_xfer(1'b0, {idx, 2'b00}, '0, rd);
      if (rd !== reg_value(c, idx))
        flag_mismatch($sformatf("register %0d readback", i), reg_value(c, idx), rd);
    end
    ctl_cfg = c;
    settings_loaded++;
  endtask

  function automatic pidss_cfg_t draw_settings(input setting_kind_t kind);
    pidss_cfg_t c;
    case (kind)
      SET_HIGH: c = '1;
      SET_LOW:  c = '0;
      default: begin
        c.gain_p          = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
        c.gain_i          = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
        c.gain_d          = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
        c.integral_window = ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(0, 3000));
        c.integral_limit  = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 100000));
        c.output_limit    = 15'($urandom);
        c.still_max_count = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(1, 6));
        c.still_max_step  = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 8));
      end
    endcase
    return c;
  endfunction

  // random error: steady runs of small steps, or a mix of walks, jumps and extremes
  task automatic next_error(output logic signed [23:0] err, output bit start);
    int     pick;
    longint w;
    pick  = $urandom_range(0, 99);
    start = 1'b0;
    if (pick < 6) begin
      start = 1'b1;
      w = longint'($urandom_range(0, 2000)) - 1000;
    end else if (steady_run && pick < 90) begin
      w = walk_err + longint'($urandom_range(0, 6)) - 3;
    end else if (pick < 60) begin
      w = walk_err + longint'($urandom_range(0, 1200)) - 600;
    end else if (pick < 75) begin
      w = walk_err;
    end else if (pick < 90) begin
      w = longint'(signed'(24'($urandom)));
    end else begin
      case ($urandom_range(0, 3))
        0:       w = 8388607;
        1:       w = -8388608;
        2:       w = 0;
        default: w = -1;
      endcase
    end
    if (w > 8388607) w = 8388607;
    if (w < -8388608) w = -8388608;
    walk_err = w;
    err = w[23:0];
  endtask

  // directed ticks: reset settings first, then a tuned setting
  tick_row_t directed_rows[19] = '{
    '{24'sd0,        1'b1, 1'b0, 1'b1, 16'sd0,      1'b0},  // reset gains are zero
    '{24'sd8388607,  1'b0, 1'b0, 1'b1, 16'sd0,      1'b0},
    '{-24'sd8388608, 1'b0, 1'b0, 1'b1, 16'sd0,      1'b0},
    '{-24'sd1,       1'b0, 1'b0, 1'b1, 16'sd0,      1'b0},
    '{24'sd1,        1'b0, 1'b0, 1'b1, 16'sd0,      1'b0},
    '{24'sd0,        1'b1, 1'b1, 1'b0, 16'sd0,      1'b0},  // tuned setting
    '{24'sd8388607,  1'b0, 1'b0, 1'b1, 16'sd32767,  1'b0},  // positive clamp
    '{-24'sd8388608, 1'b0, 1'b0, 1'b1, -16'sd32767, 1'b0},  // negative clamp
    '{-24'sd1,       1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},  // floor shift
    '{24'sd0,        1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},  // zero is non-negative
    '{24'sd500,      1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},  // accumulate
    '{24'sd900,      1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{24'sd1000,     1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},  // window edge, limit clamp
    '{24'sd1001,     1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},  // outside window, count begins
    '{24'sd1001,     1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{24'sd1003,     1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},  // standstill sets
    '{24'sd1000,     1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},
    '{-24'sd5,       1'b0, 1'b0, 1'b0, 16'sd0,      1'b0},  // flag stays, sign change
    '{-24'sd5,       1'b1, 1'b0, 1'b0, 16'sd0,      1'b0}   // start clears flag
  };

  initial begin
    pidss_cfg_t         tuned;
    logic signed [23:0] err;
    bit                 start;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_error_now  <= '0;
    in_start_move <= 1'b0;
    out_stall     <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    ctl_cfg              = '0;
    ctl_cfg.output_limit = OUTPUT_LIMIT_RST;
    integ_sum   = 0;
    last_err    = 0;
    still_cnt   = 0;
    still_on    = 1'b0;
    walk_err    = 0;
    steady_flow = 1'b0;
    steady_run  = 1'b0;

    tuned                 = '0;
    tuned.gain_p          = 16'd256;
    tuned.gain_i          = 16'd128;
    tuned.gain_d          = 16'd64;
    tuned.integral_window = 23'd1000;
    tuned.integral_limit  = 31'd1500;
    tuned.output_limit    = 15'd32767;
    tuned.still_max_count = 8'd2;
    tuned.still_max_step  = 24'd4;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].new_setup) begin
        drain_results();
        load_settings(tuned);
      end
      send_tick(directed_rows[i].err, directed_rows[i].start, directed_rows[i].typed,
                directed_rows[i].drive, directed_rows[i].still);
    end

    // random phases, extremes first
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      load_settings(draw_settings(ph == 0 ? SET_HIGH : (ph == 1 ? SET_LOW : SET_RANDOM)));
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if (k % 16 == 0) begin
          steady_run  = $urandom_range(0, 1);
          steady_flow = ($urandom_range(0, 3) == 0);
        end
        if (k == 40) drain_results();
        next_error(err, start);
        send_tick(err, start, 1'b0, '0, 1'b0);
      end
    end

    // wind down
    drain_results();
    repeat (8) @(posedge clk);
    $display("summary: %0d ticks over %0d register settings, %0d results checked",
             ticks_sent, settings_loaded, results_checked);
    $display("summary: %0d results with standstill set, %0d mismatches",
             still_seen, mismatches);
    if (mismatches == 0 && pending_drive.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
